// ===== src/drt_pkg.sv =====
// drt_pkg: shared constants and types for the dirty rectangle tracker.
// No dependencies; used by dirty_rect_tracker.
package drt_pkg;

    // Default sizes of the list and the screen
    localparam int MAX_RECTS_DEF     = 16;
    localparam int SCREEN_WIDTH_DEF  = 320;
    localparam int SCREEN_HEIGHT_DEF = 240;

    // Widths of the request and result fields
    localparam int OP_W    = 2;
    localparam int COORD_W = 16;
    localparam int OUT_X_W = 9;
    localparam int OUT_Y_W = 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_MARK  = 2'd0;
    localparam logic [OP_W-1:0] OP_FLUSH = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_MERGE,
        ST_APPEND
    } state_t;

endpackage

// ===== src/drt_ram.sv =====
// drt_ram: generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module drt_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/dirty_rect_tracker.sv =====
// dirty_rect_tracker: top level of the dirty rectangle list.
// Depends on drt_pkg and drt_ram.

// The block keeps up to MAX_RECTS half-open screen rectangles in one RAM
// with a registered read. A mark request clips its signed edges to the
// screen and drops the rectangle if it comes out empty; otherwise it is
// written to the next free entry in the cycle it is accepted. When the
// list is already full, a mark first walks all MAX_RECTS entries, one RAM
// read a cycle, folding them into a bounding box held in registers, writes
// that box to entry 0 and then appends the new rectangle as entry 1; the
// block takes no request until then. A clear request leaves a single
// full-screen entry. A flush request waits while the output is stalled:
// each entry is read from the RAM and moved into the output register, the
// final one flagged with last, and the list is then empty. A flush of an
// empty list emits nothing. Results sit in an output register, so a new
// request is taken while the last result of a flush still waits.
module dirty_rect_tracker #(
    parameter int MAX_RECTS     = drt_pkg::MAX_RECTS_DEF,
    parameter int SCREEN_WIDTH  = drt_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = drt_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [drt_pkg::OP_W-1:0]            op,
    input  logic signed [drt_pkg::COORD_W-1:0]  left,
    input  logic signed [drt_pkg::COORD_W-1:0]  top,
    input  logic signed [drt_pkg::COORD_W-1:0]  right,
    input  logic signed [drt_pkg::COORD_W-1:0]  bottom,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [drt_pkg::OUT_X_W-1:0]         rect_left,
    output logic [drt_pkg::OUT_Y_W-1:0]         rect_top,
    output logic [drt_pkg::OUT_X_W-1:0]         rect_right,
    output logic [drt_pkg::OUT_Y_W-1:0]         rect_bottom,
    output logic                                last
);

    localparam int XW = $clog2(SCREEN_WIDTH + 1);
    localparam int YW = $clog2(SCREEN_HEIGHT + 1);
    localparam int EW = 2 * XW + 2 * YW;
    localparam int AW = $clog2(MAX_RECTS);
    localparam int CW = $clog2(MAX_RECTS + 1);

    localparam logic signed [drt_pkg::COORD_W-1:0] W_S = drt_pkg::COORD_W'(SCREEN_WIDTH);
    localparam logic signed [drt_pkg::COORD_W-1:0] H_S = drt_pkg::COORD_W'(SCREEN_HEIGHT);
    localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_RECTS);
    localparam logic [EW-1:0] FULL_SCREEN =
        {XW'(0), YW'(0), XW'(SCREEN_WIDTH), YW'(SCREEN_HEIGHT)};

    drt_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic          rv_reg, rv_next;

    // held new rectangle while a merge runs
    logic [EW-1:0] new_reg, new_next;

    // bounding box accumulator
    logic [XW-1:0] acc_x0_reg, acc_x0_next, acc_x1_reg, acc_x1_next;
    logic [YW-1:0] acc_y0_reg, acc_y0_next, acc_y1_reg, acc_y1_next;

    // output register
    logic                        out_valid_reg, out_valid_next;
    logic [drt_pkg::OUT_X_W-1:0] rect_left_reg, rect_left_next;
    logic [drt_pkg::OUT_Y_W-1:0] rect_top_reg, rect_top_next;
    logic [drt_pkg::OUT_X_W-1:0] rect_right_reg, rect_right_next;
    logic [drt_pkg::OUT_Y_W-1:0] rect_bottom_reg, rect_bottom_next;
    logic                        last_reg, last_next;

    // RAM port
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    // Clip the incoming rectangle to the screen
    logic signed [drt_pkg::COORD_W-1:0] x0c, y0c, x1c, y1c;
    logic                               clip_empty;
    logic [EW-1:0]                      clip_entry;

    always_comb
    begin
        x0c        = left[drt_pkg::COORD_W-1] ? '0 : left;
        y0c        = top[drt_pkg::COORD_W-1] ? '0 : top;
        x1c        = (right > W_S) ? W_S : right;
        y1c        = (bottom > H_S) ? H_S : bottom;
        clip_empty = (x0c >= x1c) || (y0c >= y1c);
        clip_entry = {x0c[XW-1:0], y0c[YW-1:0], x1c[XW-1:0], y1c[YW-1:0]};
    end

    // Unpack the entry coming out of the RAM and fold it into the box
    logic [XW-1:0] rd_x0, rd_x1, mg_x0, mg_x1;
    logic [YW-1:0] rd_y0, rd_y1, mg_y0, mg_y1;

    assign rd_x0 = ram_rdata[EW-1 -: XW];
    assign rd_y0 = ram_rdata[EW-1-XW -: YW];
    assign rd_x1 = ram_rdata[XW+YW-1 -: XW];
    assign rd_y1 = ram_rdata[YW-1:0];

    assign mg_x0 = (rd_x0 < acc_x0_reg) ? rd_x0 : acc_x0_reg;
    assign mg_y0 = (rd_y0 < acc_y0_reg) ? rd_y0 : acc_y0_reg;
    assign mg_x1 = (rd_x1 > acc_x1_reg) ? rd_x1 : acc_x1_reg;
    assign mg_y1 = (rd_y1 > acc_y1_reg) ? rd_y1 : acc_y1_reg;

    logic in_accept, can_load, flush_last, merge_issue;

    assign in_accept   = in_valid && !in_stall;
    assign can_load    = !out_valid_reg || !out_stall;
    assign flush_last  = (ptr_reg == count_reg - CW'(1));
    assign merge_issue = (ptr_reg < COUNT_FULL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= drt_pkg::ST_IDLE;
            count_reg     <= '0;
            ptr_reg       <= '0;
            rv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            rv_reg        <= rv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_reg         <= new_next;
        acc_x0_reg      <= acc_x0_next;
        acc_y0_reg      <= acc_y0_next;
        acc_x1_reg      <= acc_x1_next;
        acc_y1_reg      <= acc_y1_next;
        rect_left_reg   <= rect_left_next;
        rect_top_reg    <= rect_top_next;
        rect_right_reg  <= rect_right_next;
        rect_bottom_reg <= rect_bottom_next;
        last_reg        <= last_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        ptr_next         = ptr_reg;
        rv_next          = 1'b0;
        new_next         = new_reg;
        acc_x0_next      = acc_x0_reg;
        acc_y0_next      = acc_y0_reg;
        acc_x1_next      = acc_x1_reg;
        acc_y1_next      = acc_y1_reg;
        out_valid_next   = out_valid_reg && out_stall;
        rect_left_next   = rect_left_reg;
        rect_top_next    = rect_top_reg;
        rect_right_next  = rect_right_reg;
        rect_bottom_next = rect_bottom_reg;
        last_next        = last_reg;
        ram_we           = 1'b0;
        ram_waddr        = '0;
        ram_wdata        = clip_entry;
        ram_re           = 1'b0;
        ram_raddr        = '0;

        case (state_reg)
            drt_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (op)
                        drt_pkg::OP_MARK:
                        begin
                            if (!clip_empty)
                            begin
                                if (count_reg == COUNT_FULL)
                                begin
                                    // hold the rectangle, start the merge walk
                                    new_next    = clip_entry;
                                    ptr_next    = '0;
                                    acc_x0_next = '1;
                                    acc_y0_next = '1;
                                    acc_x1_next = '0;
                                    acc_y1_next = '0;
                                    state_next  = drt_pkg::ST_MERGE;
                                end
                                else
                                begin
                                    ram_we     = 1'b1;
                                    ram_waddr  = count_reg[AW-1:0];
                                    count_next = count_reg + CW'(1);
                                end
                            end
                        end
                        drt_pkg::OP_CLEAR:
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = '0;
                            ram_wdata  = FULL_SCREEN;
                            count_next = CW'(1);
                        end
                        drt_pkg::OP_FLUSH:
                        begin
                            if (count_reg != '0)
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                ptr_next   = '0;
                                state_next = drt_pkg::ST_FLUSH;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            drt_pkg::ST_FLUSH:
            begin
                // rdata holds entry ptr_reg until the output register takes it
                if (can_load)
                begin
                    out_valid_next   = 1'b1;
                    rect_left_next   = drt_pkg::OUT_X_W'(rd_x0);
                    rect_top_next    = drt_pkg::OUT_Y_W'(rd_y0);
                    rect_right_next  = drt_pkg::OUT_X_W'(rd_x1);
                    rect_bottom_next = drt_pkg::OUT_Y_W'(rd_y1);
                    last_next        = flush_last;
                    if (flush_last)
                    begin
                        count_next = '0;
                        state_next = drt_pkg::ST_IDLE;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = AW'(ptr_reg + CW'(1));
                        ptr_next  = ptr_reg + CW'(1);
                    end
                end
            end

            drt_pkg::ST_MERGE:
            begin
                if (merge_issue)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_reg[AW-1:0];
                    ptr_next  = ptr_reg + CW'(1);
                    rv_next   = 1'b1;
                end
                if (rv_reg)
                begin
                    acc_x0_next = mg_x0;
                    acc_y0_next = mg_y0;
                    acc_x1_next = mg_x1;
                    acc_y1_next = mg_y1;
                    if (!merge_issue)
                    begin
                        // final entry folded in: write the box back as entry 0
                        ram_we     = 1'b1;
                        ram_waddr  = '0;
                        ram_wdata  = {mg_x0, mg_y0, mg_x1, mg_y1};
                        state_next = drt_pkg::ST_APPEND;
                    end
                end
            end

            drt_pkg::ST_APPEND:
            begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(1);
                ram_wdata  = new_reg;
                count_next = CW'(2);
                state_next = drt_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = drt_pkg::ST_IDLE;
            end
        endcase
    end

    drt_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_RECTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall    = (state_reg != drt_pkg::ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign rect_left   = rect_left_reg;
    assign rect_top    = rect_top_reg;
    assign rect_right  = rect_right_reg;
    assign rect_bottom = rect_bottom_reg;
    assign last        = last_reg;

    // The list never holds more entries than the store
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_FULL)
        else $error("entry count beyond store depth");

    // A new result only appears while a flush walks the list
    a_out_from_flush: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == drt_pkg::ST_FLUSH)
        else $error("result produced outside a flush");

    // The final result of a flush leaves the list empty
    a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == drt_pkg::ST_FLUSH && can_load && flush_last)
        |=> (count_reg == '0 && last_reg && out_valid_reg))
        else $error("flush did not empty the list");

    // A merge ends with the box and the new rectangle stored
    a_merge_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == drt_pkg::ST_APPEND |=> count_reg == CW'(2))
        else $error("merge left a wrong entry count");

endmodule
